FILE: src/vmpi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmpi_pkg
// Shared types and constants of the voxel map point insert block.
// ----------------------------------------------------------------------------
package vmpi_pkg;

    localparam int VOXEL_SLOTS  = 1024;
    localparam int MAX_CAPACITY = 32;
    localparam int SLOT_W       = $clog2(VOXEL_SLOTS);
    localparam int PT_W         = $clog2(MAX_CAPACITY);
    localparam int FILL_W       = PT_W + 1;
    localparam int COORD_W      = 24;
    localparam int CELL_W       = 20;
    localparam int POINT_W      = 3 * COORD_W;
    localparam int MAG_W        = COORD_W + 1;
    localparam int PROD_W       = 2 * MAG_W;
    localparam int ACC_W        = PROD_W + 1;
    localparam int LIM_W        = 46;
    localparam int MIN_DIV      = 16;

    // configuration register indexes
    localparam logic [1:0] REG_VOXEL_SIZE  = 2'd0;
    localparam logic [1:0] REG_CAPACITY    = 2'd1;
    localparam logic [1:0] REG_MIN_SPACING = 2'd2;
    localparam logic [1:0] REG_MAX_KEEP    = 2'd3;

    typedef enum logic [2:0] {
        ST_ADDED      = 3'd0,
        ST_NEW        = 3'd1,
        ST_FULL       = 3'd2,
        ST_CLOSE      = 3'd3,
        ST_TABLE_FULL = 3'd4,
        ST_PRUNED     = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LIM,
        S_DIV_LD,
        S_DIV,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_INS_DEC,
        S_PT_RD,
        S_DIST,
        S_CMP,
        S_WR_ADD,
        S_WR_NEW,
        S_OUT
    } t_state;

    // one slot of the voxel table
    typedef struct packed {
        logic                    valid;
        logic [FILL_W-1:0]       fill;
        logic [2:0][CELL_W-1:0]  vox_idx;
    } t_meta;

    localparam int META_W = $bits(t_meta);

endpackage

FILE: src/vmpi_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmpi_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module vmpi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/voxel_map_point_insert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_map_point_insert
// Bounded voxel table with point insertion and distance-based pruning.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis carries one command per transaction: tuser = func (0 insert,
//    1 prune), tdata = {pos_z, pos_y, pos_x}, signed Q15.8 metres.
//  - m_axis returns one result per command: tdata = {removed_count, status}.
//  - cfg channel writes voxel_size, voxel_capacity, min_point_spacing and
//    max_keep_distance (index 0..3); o_cfg_ready is always high. Write only
//    while no command is in flight.
//  - One command at a time; s_axis_tready is low from acceptance until the
//    result transaction completes. A stalled m_axis simply holds the result.
//  - Insert sequence, acceptance to result valid: spacing square, three
//    serial divides, slot scan (scan stops at the matching cell, else all
//    1024 slots), decision, a distance check per stored point checked,
//    and a table write when the point is kept. One shared 25x25 multiplier
//    forms the squared distances, one term per cycle.
//  - Prune: limit square, full 1024-slot scan, distance check per valid slot.
//  - Reset: after i_rst_n the table is cleared by a sweep over all 1024
//    slots of the slot RAM; no command is accepted until it ends.
// ----------------------------------------------------------------------------
module voxel_map_point_insert (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // [23:0] pos_x, [47:24] pos_y, [71:48] pos_z
    input  logic        s_axis_tuser,  // [0] func
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [2:0] status, [13:3] removed_count, zero
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [22:0] i_cfg_data
);

    localparam int SW  = vmpi_pkg::SLOT_W;
    localparam int PW  = vmpi_pkg::PT_W;
    localparam int FW  = vmpi_pkg::FILL_W;
    localparam int CW  = vmpi_pkg::COORD_W;
    localparam int MW  = vmpi_pkg::MAG_W;

    // configuration registers
    logic [15:0] r_voxel_size;
    logic [5:0]  r_capacity;
    logic [15:0] r_spacing;
    logic [22:0] r_max_keep;

    // control and datapath
    vmpi_pkg::t_state  r_state, n_state;
    logic                           r_func;
    logic [vmpi_pkg::POINT_W-1:0]   r_pos;
    logic [1:0]                     r_k;
    logic [4:0]                     r_step;
    logic [15:0]                    r_rem;
    logic [CW-1:0]                  r_quo;
    logic [2:0][vmpi_pkg::CELL_W-1:0] r_cell;
    logic [SW-1:0]                  r_slot;
    logic [SW-1:0]                  r_free;
    logic                           r_free_ok;
    logic                           r_hit;
    logic [FW-1:0]                  r_fill;
    logic [PW-1:0]                  r_j;
    logic [vmpi_pkg::LIM_W-1:0]     r_lim;
    logic [vmpi_pkg::PROD_W-1:0]    r_prod;
    logic [vmpi_pkg::ACC_W-1:0]     r_acc;
    vmpi_pkg::t_status              r_status;
    logic [10:0]                    r_count;

    // RAM ports
    logic                           meta_we;
    vmpi_pkg::t_meta                meta_wdata;
    logic [vmpi_pkg::META_W-1:0]    meta_rdata;
    vmpi_pkg::t_meta                meta_rd;
    logic                           pt_we;
    logic [SW+PW-1:0]               pt_waddr;
    logic [SW+PW-1:0]               pt_raddr;
    logic [vmpi_pkg::POINT_W-1:0]   pt_rdata;

    // shared multiplier
    logic [MW-1:0]                  mul_a;
    logic [vmpi_pkg::PROD_W-1:0]    mul_p;

    // helper signals
    logic [15:0]      div_eff;
    logic [FW-1:0]    cap_eff;
    logic [CW-1:0]    pos_k;
    logic [CW-1:0]    stored_k;
    logic [MW-1:0]    diff_k;
    logic [MW-1:0]    mag_diff;
    logic [CW-1:0]    pos_mag;
    logic [16:0]      rem_sh;
    logic             rem_ge;
    logic             hit_now;
    logic             last_slot;
    logic             too_close;
    logic             far_away;

    assign meta_rd = vmpi_pkg::t_meta'(meta_rdata);

    vmpi_ram #(
        .WIDTH (vmpi_pkg::META_W),
        .DEPTH (vmpi_pkg::VOXEL_SLOTS)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (r_slot),
        .i_wdata (meta_wdata),
        .i_raddr (r_slot),
        .o_rdata (meta_rdata)
    );

    vmpi_ram #(
        .WIDTH (vmpi_pkg::POINT_W),
        .DEPTH (vmpi_pkg::VOXEL_SLOTS * vmpi_pkg::MAX_CAPACITY)
    ) u_point_ram (
        .i_clk   (i_clk),
        .i_we    (pt_we),
        .i_waddr (pt_waddr),
        .i_wdata (r_pos),
        .i_raddr (pt_raddr),
        .o_rdata (pt_rdata)
    );

    // effective divisor and capacity
    assign div_eff = (r_voxel_size < 16'(vmpi_pkg::MIN_DIV)) ?
                     16'(vmpi_pkg::MIN_DIV) : r_voxel_size;
    assign cap_eff = (r_capacity == 6'd0) ? FW'(1) :
                     (r_capacity > 6'(vmpi_pkg::MAX_CAPACITY)) ?
                     FW'(vmpi_pkg::MAX_CAPACITY) : FW'(r_capacity);

    // coordinate k of the command and of the stored point
    always_comb begin
        case (r_k)
            2'd0:    begin pos_k = r_pos[23:0];  stored_k = pt_rdata[23:0];  end
            2'd1:    begin pos_k = r_pos[47:24]; stored_k = pt_rdata[47:24]; end
            default: begin pos_k = r_pos[71:48]; stored_k = pt_rdata[71:48]; end
        endcase
    end

    assign pos_mag  = pos_k[CW-1] ? (CW'(0) - pos_k) : pos_k;
    assign diff_k   = {pos_k[CW-1], pos_k} - {stored_k[CW-1], stored_k};
    assign mag_diff = diff_k[MW-1] ? (MW'(0) - diff_k) : diff_k;

    // restoring divider step
    assign rem_sh = {r_rem, r_quo[CW-1]};
    assign rem_ge = (rem_sh >= {1'b0, div_eff});

    // multiplier operand: limit radius in S_LIM, distance term otherwise
    always_comb begin
        if (r_state == vmpi_pkg::S_LIM) begin
            mul_a = r_func ? MW'(r_max_keep) : MW'(r_spacing);
        end else begin
            mul_a = mag_diff;
        end
    end
    assign mul_p = mul_a * mul_a;

    assign hit_now   = meta_rd.valid && (meta_rd.vox_idx == r_cell);
    assign last_slot = (r_slot == SW'(vmpi_pkg::VOXEL_SLOTS - 1));
    assign too_close = (r_acc <= vmpi_pkg::ACC_W'(r_lim));
    assign far_away  = !too_close;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            vmpi_pkg::S_CLEAR:    if (last_slot) n_state = vmpi_pkg::S_IDLE;
            vmpi_pkg::S_IDLE:     if (s_axis_tvalid) n_state = vmpi_pkg::S_LIM;
            vmpi_pkg::S_LIM:      n_state = r_func ? vmpi_pkg::S_SCAN_RD
                                                   : vmpi_pkg::S_DIV_LD;
            vmpi_pkg::S_DIV_LD:   n_state = vmpi_pkg::S_DIV;
            vmpi_pkg::S_DIV: begin
                if (r_step == 5'(CW - 1)) begin
                    n_state = (r_k == 2'd2) ? vmpi_pkg::S_SCAN_RD : vmpi_pkg::S_DIV_LD;
                end
            end
            vmpi_pkg::S_SCAN_RD:  n_state = vmpi_pkg::S_SCAN_CHK;
            vmpi_pkg::S_SCAN_CHK: begin
                if (r_func) begin
                    if (meta_rd.valid)  n_state = vmpi_pkg::S_DIST;
                    else if (last_slot) n_state = vmpi_pkg::S_OUT;
                    else                n_state = vmpi_pkg::S_SCAN_RD;
                end else begin
                    if (hit_now || last_slot) n_state = vmpi_pkg::S_INS_DEC;
                    else                      n_state = vmpi_pkg::S_SCAN_RD;
                end
            end
            vmpi_pkg::S_INS_DEC: begin
                if (r_hit) begin
                    if (r_fill >= cap_eff)       n_state = vmpi_pkg::S_OUT;
                    else if (r_fill == FW'(0))   n_state = vmpi_pkg::S_WR_ADD;
                    else                         n_state = vmpi_pkg::S_PT_RD;
                end else begin
                    n_state = r_free_ok ? vmpi_pkg::S_WR_NEW : vmpi_pkg::S_OUT;
                end
            end
            vmpi_pkg::S_PT_RD:    n_state = vmpi_pkg::S_DIST;
            vmpi_pkg::S_DIST:     if (r_k == 2'd3) n_state = vmpi_pkg::S_CMP;
            vmpi_pkg::S_CMP: begin
                if (r_func) begin
                    n_state = last_slot ? vmpi_pkg::S_OUT : vmpi_pkg::S_SCAN_RD;
                end else if (too_close) begin
                    n_state = vmpi_pkg::S_OUT;
                end else if (FW'(r_j) + FW'(1) == r_fill) begin
                    n_state = vmpi_pkg::S_WR_ADD;
                end else begin
                    n_state = vmpi_pkg::S_PT_RD;
                end
            end
            vmpi_pkg::S_WR_ADD:   n_state = vmpi_pkg::S_OUT;
            vmpi_pkg::S_WR_NEW:   n_state = vmpi_pkg::S_OUT;
            vmpi_pkg::S_OUT:      if (m_axis_tready) n_state = vmpi_pkg::S_IDLE;
            default:              n_state = vmpi_pkg::S_IDLE;
        endcase
    end

    // RAM control and port outputs
    always_comb begin
        meta_we    = 1'b0;
        meta_wdata = '0;
        pt_we      = 1'b0;
        pt_waddr   = {r_slot, PW'(0)};
        pt_raddr   = {r_slot, r_j};
        case (r_state)
            vmpi_pkg::S_CLEAR: begin
                meta_we = 1'b1;
            end
            vmpi_pkg::S_CMP: begin
                // prune drops the slot; the rest of the word no longer matters
                meta_we = r_func && far_away;
            end
            vmpi_pkg::S_WR_ADD: begin
                meta_we            = 1'b1;
                meta_wdata.valid   = 1'b1;
                meta_wdata.fill    = r_fill + FW'(1);
                meta_wdata.vox_idx = r_cell;
                pt_we              = 1'b1;
                pt_waddr           = {r_slot, r_fill[PW-1:0]};
            end
            vmpi_pkg::S_WR_NEW: begin
                meta_we            = 1'b1;
                meta_wdata.valid   = 1'b1;
                meta_wdata.fill    = FW'(1);
                meta_wdata.vox_idx = r_cell;
                pt_we              = 1'b1;
            end
            default: begin
                meta_we = 1'b0;
            end
        endcase
    end

    assign s_axis_tready = (r_state == vmpi_pkg::S_IDLE);
    assign m_axis_tvalid = (r_state == vmpi_pkg::S_OUT);
    assign m_axis_tdata  = {2'b00, r_count, r_status};
    assign o_cfg_ready   = 1'b1;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= vmpi_pkg::S_CLEAR;
            r_voxel_size <= 16'd256;
            r_capacity   <= 6'd20;
            r_spacing    <= 16'd13;
            r_max_keep   <= 23'd38400;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    vmpi_pkg::REG_VOXEL_SIZE:  r_voxel_size <= i_cfg_data[15:0];
                    vmpi_pkg::REG_CAPACITY:    r_capacity   <= i_cfg_data[5:0];
                    vmpi_pkg::REG_MIN_SPACING: r_spacing    <= i_cfg_data[15:0];
                    vmpi_pkg::REG_MAX_KEEP:    r_max_keep   <= i_cfg_data;
                    default:                   r_capacity   <= r_capacity;
                endcase
            end
        end
    end

    // slot counter: clearing sweep and table scans
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else begin
            case (r_state)
                vmpi_pkg::S_CLEAR: r_slot <= r_slot + SW'(1);
                vmpi_pkg::S_LIM:   r_slot <= '0;
                vmpi_pkg::S_SCAN_CHK: begin
                    if (r_func ? !meta_rd.valid : !hit_now) r_slot <= r_slot + SW'(1);
                end
                vmpi_pkg::S_INS_DEC: begin
                    if (!r_hit) r_slot <= r_free;
                end
                vmpi_pkg::S_CMP: begin
                    if (r_func) r_slot <= r_slot + SW'(1);
                end
                default: r_slot <= r_slot;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            vmpi_pkg::S_IDLE: begin
                r_func    <= s_axis_tuser;
                r_pos     <= s_axis_tdata;
                r_count   <= '0;
                r_status  <= s_axis_tuser ? vmpi_pkg::ST_PRUNED : vmpi_pkg::ST_ADDED;
                r_k       <= 2'd0;
                r_j       <= '0;
                r_hit     <= 1'b0;
                r_free_ok <= 1'b0;
            end
            vmpi_pkg::S_LIM: begin
                r_lim <= mul_p[vmpi_pkg::LIM_W-1:0];
            end
            vmpi_pkg::S_DIV_LD: begin
                r_rem  <= '0;
                r_quo  <= pos_mag;
                r_step <= '0;
            end
            vmpi_pkg::S_DIV: begin
                r_rem  <= rem_ge ? 16'(rem_sh - {1'b0, div_eff}) : rem_sh[15:0];
                r_quo  <= {r_quo[CW-2:0], rem_ge};
                r_step <= r_step + 5'd1;
                if (r_step == 5'(CW - 1)) begin
                    // final quotient bit lands here; apply the sign of the input
                    r_cell[r_k] <= pos_k[CW-1] ?
                        (vmpi_pkg::CELL_W'(0) - {r_quo[vmpi_pkg::CELL_W-2:0], rem_ge}) :
                        {r_quo[vmpi_pkg::CELL_W-2:0], rem_ge};
                    if (r_k != 2'd2) r_k <= r_k + 2'd1;
                end
            end
            vmpi_pkg::S_SCAN_CHK: begin
                r_k   <= 2'd0;
                r_acc <= '0;
                r_j   <= '0;
                if (!r_func) begin
                    if (hit_now) begin
                        r_hit  <= 1'b1;
                        r_fill <= meta_rd.fill;
                    end else if (!meta_rd.valid && !r_free_ok) begin
                        r_free_ok <= 1'b1;
                        r_free    <= r_slot;
                    end
                end
            end
            vmpi_pkg::S_INS_DEC: begin
                if (r_hit) begin
                    if (r_fill >= cap_eff) r_status <= vmpi_pkg::ST_FULL;
                end else if (!r_free_ok) begin
                    r_status <= vmpi_pkg::ST_TABLE_FULL;
                end
            end
            vmpi_pkg::S_PT_RD: begin
                r_k   <= 2'd0;
                r_acc <= '0;
            end
            vmpi_pkg::S_DIST: begin
                // one squared term per cycle, registered and summed in the next cycle
                if (r_k != 2'd3) r_prod <= mul_p;
                if (r_k != 2'd0) r_acc  <= r_acc + vmpi_pkg::ACC_W'(r_prod);
                r_k <= r_k + 2'd1;
            end
            vmpi_pkg::S_CMP: begin
                if (r_func) begin
                    if (far_away) r_count <= r_count + 11'd1;
                end else if (too_close) begin
                    r_status <= vmpi_pkg::ST_CLOSE;
                end else begin
                    r_j <= r_j + PW'(1);
                end
            end
            vmpi_pkg::S_WR_NEW: begin
                r_status <= vmpi_pkg::ST_NEW;
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // input and output sides never open together: one command at a time
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("command accepted while a result is pending");

    // a command transaction closes the input side on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input side still ready after a command");

    // the point loop never reads past the voxel's fill
    a_point_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vmpi_pkg::S_CMP && !r_func) |-> (FW'(r_j) < r_fill))
        else $error("point index beyond voxel fill");

endmodule
